// File: design/kcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key change event scanner package
// Shared constants, register codes and the types passed between the input
// tracker, the event emitter and the register block.
// ----------------------------------------------------------------------------
package kcs_pkg;

   localparam int NUM_CHIPS_DEFAULT     = 3;
   localparam int PINS_PER_CHIP_DEFAULT = 16;

   localparam int WORD_W   = 16;
   localparam int CHIP_W   = 2;
   localparam int PIN_W    = 4;
   localparam int COUNT_W  = 7;
   localparam int FAST_W   = 8;
   localparam int PERIOD_W = 10;
   localparam int ADDR_W   = 5;
   localparam int DATA_W   = 32;

   localparam logic [COUNT_W-1:0]  IDLE_THRESHOLD_RESET = 7'd10;
   localparam logic [COUNT_W-1:0]  IDLE_CAP_RESET       = 7'd100;
   localparam logic [CHIP_W-1:0]   SCROLL_CHIP_RESET    = 2'd1;
   localparam logic [PIN_W-1:0]    SCROLL_PIN_RESET     = 4'd6;
   localparam logic [FAST_W-1:0]   FAST_PERIOD_RESET    = 8'd5;
   localparam logic [PERIOD_W-1:0] SLOW_PERIOD_RESET    = 10'd50;

   localparam logic [WORD_W-1:0] ALL_RELEASED = 16'hFFFF;

   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_WAKE = 1'b1;

   typedef enum logic [2:0] {
      REG_IDLE_THRESHOLD = 3'd0,
      REG_IDLE_CAP       = 3'd1,
      REG_SCROLL_CHIP    = 3'd2,
      REG_SCROLL_PIN     = 3'd3,
      REG_FAST_PERIOD    = 3'd4,
      REG_SLOW_PERIOD    = 3'd5
   } cfg_reg_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  idle_threshold;
      logic [COUNT_W-1:0]  idle_cap;
      logic [CHIP_W-1:0]   scroll_chip;
      logic [PIN_W-1:0]    scroll_pin;
      logic [FAST_W-1:0]   fast_period_ms;
      logic [PERIOD_W-1:0] slow_period_ms;
   } cfg_type;

   typedef struct packed {
      logic [WORD_W-1:0]   changed;
      logic [WORD_W-1:0]   word;
      logic [CHIP_W-1:0]   chip;
      logic                rearm;
      logic [COUNT_W-1:0]  idle_count;
      logic                slow_scan;
      logic [PERIOD_W-1:0] next_period_ms;
   } job_type;

endpackage

// File: design/key_change_event_scanner_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key change event scanner unit
// Turns expander port words into key press and release items and tracks idle
// scans for slow scanning and wake re-arming.
// ----------------------------------------------------------------------------
// Each accepted item yields one result per changed pin, lowest pin first, at
// one result per cycle while rsp_stall is low, or a single result without an
// event when no key changed; the event emitter sends one changed pin per
// cycle unless the result port is stalled.
// The next item is taken into a one-deep input register while the results of
// the previous one are still being delivered, so items follow back to back.
// The state update for an item is made when it moves from the input register
// to the emitter, and needs no clearing pass after reset.
module key_change_event_scanner_unit
   import kcs_pkg::*;
#(
   parameter int NUM_CHIPS     = NUM_CHIPS_DEFAULT,
   parameter int PINS_PER_CHIP = PINS_PER_CHIP_DEFAULT
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_kind,
   input  logic [CHIP_W-1:0]   req_chip,
   input  logic [WORD_W-1:0]   req_port_word,
   input  logic                req_read_ok,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_event_valid,
   output logic [CHIP_W-1:0]   rsp_key_chip,
   output logic [PIN_W-1:0]    rsp_key_pin,
   output logic                rsp_pressed,
   output logic                rsp_scroll_key,
   output logic                rsp_last,
   output logic [COUNT_W-1:0]  rsp_idle_count,
   output logic                rsp_slow_scan,
   output logic                rsp_rearm_wake,
   output logic [PERIOD_W-1:0] rsp_next_period_ms,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [ADDR_W-1:0]   csr_paddr,
   input  logic [DATA_W-1:0]   csr_pwdata,
   output logic [DATA_W-1:0]   csr_prdata,
   output logic                csr_pready
);

   cfg_type cfg;
   job_type job;
   logic    job_valid;
   logic    job_ready;

   kcs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   kcs_track #(
      .NUM_CHIPS     (NUM_CHIPS),
      .PINS_PER_CHIP (PINS_PER_CHIP)
   ) u_track (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_chip      (req_chip),
      .req_port_word (req_port_word),
      .req_read_ok   (req_read_ok),
      .cfg           (cfg),
      .job_ready     (job_ready),
      .job_valid     (job_valid),
      .job           (job)
   );

   kcs_emit u_emit (
      .clock              (clock),
      .reset              (reset),
      .job_valid          (job_valid),
      .job                (job),
      .job_ready          (job_ready),
      .cfg                (cfg),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_valid    (rsp_event_valid),
      .rsp_key_chip       (rsp_key_chip),
      .rsp_key_pin        (rsp_key_pin),
      .rsp_pressed        (rsp_pressed),
      .rsp_scroll_key     (rsp_scroll_key),
      .rsp_last           (rsp_last),
      .rsp_idle_count     (rsp_idle_count),
      .rsp_slow_scan      (rsp_slow_scan),
      .rsp_rearm_wake     (rsp_rearm_wake),
      .rsp_next_period_ms (rsp_next_period_ms)
   );

endmodule

// File: design/kcs_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key change event scanner register block
// Holds the six configuration registers behind a simple APB-style port.
// ----------------------------------------------------------------------------
module kcs_csr
   import kcs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   cfg_reg_type reg_sel;
   logic        write_en;

   assign csr_pready = 1'b1;
   assign reg_sel    = cfg_reg_type'(csr_paddr[ADDR_W-1:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_sel)
            REG_IDLE_THRESHOLD: cfg_in.idle_threshold = csr_pwdata[COUNT_W-1:0];
            REG_IDLE_CAP:       cfg_in.idle_cap       = csr_pwdata[COUNT_W-1:0];
            REG_SCROLL_CHIP:    cfg_in.scroll_chip    = csr_pwdata[CHIP_W-1:0];
            REG_SCROLL_PIN:     cfg_in.scroll_pin     = csr_pwdata[PIN_W-1:0];
            REG_FAST_PERIOD:    cfg_in.fast_period_ms = csr_pwdata[FAST_W-1:0];
            REG_SLOW_PERIOD:    cfg_in.slow_period_ms = csr_pwdata[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_IDLE_THRESHOLD: csr_prdata = DATA_W'(cfg_ff.idle_threshold);
         REG_IDLE_CAP:       csr_prdata = DATA_W'(cfg_ff.idle_cap);
         REG_SCROLL_CHIP:    csr_prdata = DATA_W'(cfg_ff.scroll_chip);
         REG_SCROLL_PIN:     csr_prdata = DATA_W'(cfg_ff.scroll_pin);
         REG_FAST_PERIOD:    csr_prdata = DATA_W'(cfg_ff.fast_period_ms);
         REG_SLOW_PERIOD:    csr_prdata = DATA_W'(cfg_ff.slow_period_ms);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.idle_threshold <= IDLE_THRESHOLD_RESET;
         cfg_ff.idle_cap       <= IDLE_CAP_RESET;
         cfg_ff.scroll_chip    <= SCROLL_CHIP_RESET;
         cfg_ff.scroll_pin     <= SCROLL_PIN_RESET;
         cfg_ff.fast_period_ms <= FAST_PERIOD_RESET;
         cfg_ff.slow_period_ms <= SLOW_PERIOD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: design/kcs_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key change event scanner input tracker
// Registers the incoming item, keeps the last word per chip and the idle scan
// state, and hands a job with the changed-pin mask to the emitter.
// ----------------------------------------------------------------------------
module kcs_track
   import kcs_pkg::*;
#(
   parameter int NUM_CHIPS     = NUM_CHIPS_DEFAULT,
   parameter int PINS_PER_CHIP = PINS_PER_CHIP_DEFAULT
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_kind,
   input  logic [CHIP_W-1:0] req_chip,
   input  logic [WORD_W-1:0] req_port_word,
   input  logic              req_read_ok,
   input  cfg_type           cfg,
   input  logic              job_ready,
   output logic              job_valid,
   output job_type           job
);

   localparam int KEY_BITS = (PINS_PER_CHIP < WORD_W) ? PINS_PER_CHIP : WORD_W;
   localparam logic [WORD_W-1:0] KEY_MASK = WORD_W'((64'd1 << KEY_BITS) - 64'd1);

   logic                valid_ff, valid_in;
   logic                kind_ff;
   logic [CHIP_W-1:0]   chip_ff;
   logic [WORD_W-1:0]   word_ff;
   logic                ok_ff;

   logic [WORD_W-1:0]   prev_ff [NUM_CHIPS];
   logic [COUNT_W-1:0]  idle_ff, idle_in;
   logic                press_ff, press_in;
   logic                armed_ff, armed_in;

   logic                take;
   logic                accept;
   logic                in_range;
   logic                end_of_scan;
   logic [WORD_W-1:0]   word_eff;
   logic [WORD_W-1:0]   prev_sel;
   logic                press_now;
   logic                slow_now;
   logic                rearm_now;

   assign take      = valid_ff && job_ready;
   assign req_stall = valid_ff && !job_ready;
   assign accept    = req_valid && !req_stall;
   assign job_valid = valid_ff;

   assign in_range    = (32'(chip_ff) < 32'(NUM_CHIPS));
   assign end_of_scan = (32'(chip_ff) == 32'(NUM_CHIPS - 1));
   assign word_eff    = (ok_ff ? word_ff : ALL_RELEASED) & KEY_MASK;
   assign press_now   = press_ff || (word_eff != KEY_MASK);

   always_comb begin
      prev_sel = '0;
      for (int i = 0; i < NUM_CHIPS; i++) begin
         if (32'(chip_ff) == 32'(i)) begin
            prev_sel = prev_ff[i];
         end
      end
   end

   always_comb begin
      idle_in   = idle_ff;
      press_in  = press_ff;
      armed_in  = armed_ff;
      rearm_now = 1'b0;
      if (kind_ff == KIND_WAKE) begin
         idle_in  = '0;
         armed_in = 1'b0;
      end else if (in_range) begin
         press_in = press_now;
         if (end_of_scan) begin
            press_in = 1'b0;
            if (press_now) begin
               idle_in = '0;
            end else if (idle_ff < cfg.idle_cap) begin
               idle_in = idle_ff + 7'd1;
            end
            if ((idle_in >= cfg.idle_threshold) && !armed_ff) begin
               armed_in  = 1'b1;
               rearm_now = 1'b1;
            end
         end
      end
   end

   assign slow_now = (idle_in >= cfg.idle_threshold);

   always_comb begin
      job.changed        = '0;
      job.word           = word_eff;
      job.chip           = chip_ff;
      job.rearm          = rearm_now;
      job.idle_count     = idle_in;
      job.slow_scan      = slow_now;
      job.next_period_ms = slow_now ? cfg.slow_period_ms
                                    : PERIOD_W'(cfg.fast_period_ms);
      if ((kind_ff == KIND_READ) && in_range) begin
         job.changed = (word_eff ^ prev_sel) & KEY_MASK;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_kind;
         chip_ff <= req_chip;
         word_ff <= req_port_word;
         ok_ff   <= req_read_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idle_ff  <= '0;
         press_ff <= 1'b0;
         armed_ff <= 1'b1;
         for (int i = 0; i < NUM_CHIPS; i++) begin
            prev_ff[i] <= KEY_MASK;
         end
      end else begin
         valid_ff <= valid_in;
         if (take) begin
            idle_ff  <= idle_in;
            press_ff <= press_in;
            armed_ff <= armed_in;
            for (int i = 0; i < NUM_CHIPS; i++) begin
               if ((kind_ff == KIND_READ) && (32'(chip_ff) == 32'(i))) begin
                  prev_ff[i] <= word_eff;
               end
            end
         end
      end
   end

endmodule

// File: design/kcs_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key change event scanner event emitter
// Holds one job and sends one result per changed pin, lowest pin first, or a
// single result without an event when nothing changed.
// ----------------------------------------------------------------------------
module kcs_emit
   import kcs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   input  job_type             job,
   output logic                job_ready,
   input  cfg_type             cfg,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_event_valid,
   output logic [CHIP_W-1:0]   rsp_key_chip,
   output logic [PIN_W-1:0]    rsp_key_pin,
   output logic                rsp_pressed,
   output logic                rsp_scroll_key,
   output logic                rsp_last,
   output logic [COUNT_W-1:0]  rsp_idle_count,
   output logic                rsp_slow_scan,
   output logic                rsp_rearm_wake,
   output logic [PERIOD_W-1:0] rsp_next_period_ms
);

   logic              active_ff, active_in;
   job_type           job_ff, job_in;
   logic [WORD_W-1:0] lowest;
   logic [WORD_W-1:0] remaining;
   logic [PIN_W-1:0]  pin_idx;
   logic              has_event;
   logic              is_last;
   logic              fire;
   logic              done;

   assign lowest    = job_ff.changed & (~job_ff.changed + 16'd1);
   assign remaining = job_ff.changed & ~lowest;
   assign has_event = |job_ff.changed;
   assign is_last   = (remaining == '0);

   always_comb begin
      pin_idx = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (lowest[i]) begin
            pin_idx = pin_idx | PIN_W'(i);
         end
      end
   end

   assign fire      = active_ff && !rsp_stall;
   assign done      = fire && is_last;
   assign job_ready = !active_ff || done;

   assign rsp_valid          = active_ff;
   assign rsp_event_valid    = has_event;
   assign rsp_key_chip       = has_event ? job_ff.chip : '0;
   assign rsp_key_pin        = pin_idx;
   assign rsp_pressed        = has_event && !job_ff.word[pin_idx];
   assign rsp_scroll_key     = has_event && (job_ff.chip == cfg.scroll_chip)
                               && (pin_idx == cfg.scroll_pin);
   assign rsp_last           = is_last;
   assign rsp_idle_count     = job_ff.idle_count;
   assign rsp_slow_scan      = job_ff.slow_scan;
   assign rsp_rearm_wake     = is_last && job_ff.rearm;
   assign rsp_next_period_ms = job_ff.next_period_ms;

   always_comb begin
      active_in = active_ff;
      job_in    = job_ff;
      if (job_valid && job_ready) begin
         active_in = 1'b1;
         job_in    = job;
      end else if (done) begin
         active_in = 1'b0;
      end else if (fire) begin
         job_in.changed = remaining;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

endmodule

// File: design/kcs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key change event scanner checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module kcs_checker
   import kcs_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic                rsp_event_valid,
   input logic [CHIP_W-1:0]   rsp_key_chip,
   input logic [PIN_W-1:0]    rsp_key_pin,
   input logic                rsp_pressed,
   input logic                rsp_scroll_key,
   input logic                rsp_last,
   input logic [COUNT_W-1:0]  rsp_idle_count,
   input logic                rsp_slow_scan,
   input logic                rsp_rearm_wake,
   input logic [PERIOD_W-1:0] rsp_next_period_ms
);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_key_pin)
         && $stable(rsp_key_chip) && $stable(rsp_last)
         && $stable(rsp_idle_count) && $stable(rsp_next_period_ms))
      else $error("Stalled result item changed.");

   a_no_event_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_event_valid |-> rsp_last && rsp_key_chip == '0
         && rsp_key_pin == '0 && !rsp_pressed && !rsp_scroll_key)
      else $error("Result item without an event is not a clean final item.");

   a_rearm_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rearm_wake |-> rsp_last && rsp_slow_scan)
      else $error("Wake re-arm pulse outside a final slow-scan item.");

   a_pin_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_event_valid && !rsp_last
         |=> rsp_valid && rsp_event_valid && rsp_key_pin > $past(rsp_key_pin)
            && rsp_key_chip == $past(rsp_key_chip)
            && rsp_idle_count == $past(rsp_idle_count))
      else $error("Events of one item are not in rising pin order.");

endmodule

bind key_change_event_scanner_unit kcs_checker u_kcs_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_event_valid    (rsp_event_valid),
   .rsp_key_chip       (rsp_key_chip),
   .rsp_key_pin        (rsp_key_pin),
   .rsp_pressed        (rsp_pressed),
   .rsp_scroll_key     (rsp_scroll_key),
   .rsp_last           (rsp_last),
   .rsp_idle_count     (rsp_idle_count),
   .rsp_slow_scan      (rsp_slow_scan),
   .rsp_rearm_wake     (rsp_rearm_wake),
   .rsp_next_period_ms (rsp_next_period_ms)
);
